// File: design/psc_pkg.sv
package psc_pkg;

  // Configuration register indexes.
  localparam logic [2:0] RegCrcWord     = 3'd0;
  localparam logic [2:0] RegSensCoeff   = 3'd1;
  localparam logic [2:0] RegOffsetCoeff = 3'd2;
  localparam logic [2:0] RegSensTemp    = 3'd3;
  localparam logic [2:0] RegOffsetTemp  = 3'd4;
  localparam logic [2:0] RegRefTemp     = 3'd5;
  localparam logic [2:0] RegTempSlope   = 3'd6;
  localparam logic [2:0] RegThreshold   = 3'd7;

  localparam int NumWords    = 7;
  localparam int WordW       = 16;
  localparam int ThrW        = 30;
  localparam int CfgIdxW     = 3;
  localparam int RawW        = 24;
  localparam int TempW       = 19;
  localparam int PressW      = 31;
  localparam int InDataW     = 48;
  localparam int OutDataW    = 56;
  localparam int NumStages   = 11;

  localparam int TempBase    = 2000;
  localparam int VeryColdOfs = 1500 + TempBase;
  localparam longint PressMax = 64'sd1073741823;
  localparam longint PressMin = -64'sd1073741824;

  localparam logic [15:0] CrcPoly     = 16'h3000;
  localparam logic [15:0] CrcDataMask = 16'h0FFF;
  localparam logic [15:0] CrcMsb      = 16'h8000;

  typedef logic [NumWords-1:0][WordW-1:0] prom_words_t;

  typedef struct packed {
    logic busy;
    logic bad;
  } crc_status_t;

  // One byte through the CRC-4 shift register, eight steps.
  function automatic logic [15:0] crc4_byte(input logic [15:0] rem_in);
    logic [15:0] rem;
    rem = rem_in;
    for (int b = 0; b < 8; b++) begin
      if ((rem & CrcMsb) != 16'h0000) begin
        rem = {rem[14:0], 1'b0} ^ CrcPoly;
      end else begin
        rem = {rem[14:0], 1'b0};
      end
    end
    return rem;
  endfunction

endpackage

// File: design/pressure_sensor_compensation.sv
// Second-order compensated barometric sensor conversion.
// Input stream: one request carries a raw pressure and a raw temperature
// conversion. Output stream: one result per request with temperature in
// 0.01 C, pressure in 0.1 mbar (saturated to 31 bits), a submerged flag and
// a calibration CRC failure flag.
// Calibration words and the threshold are to be written through the plain write
// port only while no request is in flight; the block itself does not enforce
// this. Each write to a calibration word starts a CRC-4 check that walks one
// byte a cycle over 16 bytes; the input side is not ready while it runs.
// The datapath is an 11-stage pipeline that takes one request every cycle
// unless the output stalls or a CRC check runs.
// The pipeline advances as a whole; when the receiver holds tready low
// with a result waiting, every stage holds and s_axis_tready drops.
// Reset clears all calibration words, the threshold and all valid bits;
// the CRC of all-zero words matches, so crc_bad reads zero after reset.
module pressure_sensor_compensation (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [psc_pkg::InDataW-1:0]        s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [18:0] temperature_centi, [49:19] pressure_tenth_mbar, [50] submerged,
  // [51] crc_bad, [55:52] zero
  output logic [psc_pkg::OutDataW-1:0]       m_axis_tdata,
  input  logic                               cfg_we_i,
  input  logic [psc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [psc_pkg::ThrW-1:0]           cfg_wdata_i
);

  psc_pkg::prom_words_t      prom_q;
  logic [psc_pkg::ThrW-1:0]  thr_q;
  psc_pkg::crc_status_t      crc_st;
  logic                      crc_start;

  logic [psc_pkg::NumStages-1:0] v_q;
  logic adv, in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prom_q <= '0;
      thr_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == psc_pkg::RegThreshold) begin
        thr_q <= cfg_wdata_i;
      end else begin
        prom_q[cfg_idx_i] <= cfg_wdata_i[psc_pkg::WordW-1:0];
      end
    end
  end

  assign crc_start = cfg_we_i && (cfg_idx_i != psc_pkg::RegThreshold);

  psc_crc u_crc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (crc_start),
    .words_i  (prom_q),
    .status_o (crc_st)
  );

  assign adv           = !v_q[psc_pkg::NumStages-1] || m_axis_tready;
  assign s_axis_tready = adv && !crc_st.busy;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[psc_pkg::NumStages-2:0], in_fire};
    end
  end

  logic [15:0] c1, c2, c3, c4, c5, c6;
  assign c1 = prom_q[psc_pkg::RegSensCoeff];
  assign c2 = prom_q[psc_pkg::RegOffsetCoeff];
  assign c3 = prom_q[psc_pkg::RegSensTemp];
  assign c4 = prom_q[psc_pkg::RegOffsetTemp];
  assign c5 = prom_q[psc_pkg::RegRefTemp];
  assign c6 = prom_q[psc_pkg::RegTempSlope];

  // Stage 1: temperature difference from the reference.
  logic signed [24:0] s1_dt_q, s1_dt_d;
  logic [23:0]        s1_d1_q;
  assign s1_dt_d = $signed({1'b0, s_axis_tdata[47:24]}) - $signed({1'b0, c5, 8'h00});

  // Stage 2: products with dt.
  logic signed [41:0] s2_pt_d, s2_po_d, s2_ps_d, s2_pt_q, s2_po_q, s2_ps_q;
  logic signed [49:0] s2_sq_d;
  logic [47:0]        s2_dtsq_q;
  logic [23:0]        s2_d1_q;
  assign s2_pt_d = s1_dt_q * $signed({1'b0, c6});
  assign s2_po_d = s1_dt_q * $signed({1'b0, c4});
  assign s2_ps_d = s1_dt_q * $signed({1'b0, c3});
  assign s2_sq_d = s1_dt_q * s1_dt_q;

  // Stage 3: first-order terms and the temperature correction.
  logic signed [18:0] s3_tdiff_d, s3_tdiff_q;
  logic signed [39:0] s3_off1_d, s3_sens1_d, s3_off1_q, s3_sens1_q;
  logic [49:0]        s3_dtsq3;
  logic [16:0]        s3_t2_d, s3_t2_q;
  logic [23:0]        s3_d1_q;
  assign s3_tdiff_d = s2_pt_q[41:23];
  assign s3_off1_d  = $signed({8'h00, c2, 16'h0000})
                    + $signed({{5{s2_po_q[41]}}, s2_po_q[41:7]});
  assign s3_sens1_d = $signed({9'h000, c1, 15'h0000})
                    + $signed({{6{s2_ps_q[41]}}, s2_ps_q[41:8]});
  assign s3_dtsq3   = {2'b00, s2_dtsq_q} + {1'b0, s2_dtsq_q, 1'b0};
  assign s3_t2_d    = s3_tdiff_d[18] ? s3_dtsq3[49:33] : {5'b00000, s2_dtsq_q[47:36]};

  // Stage 4: squares of the temperature distances, corrected temperature.
  logic signed [19:0] s4_tdiff2;
  logic signed [37:0] s4_sq_full;
  logic signed [39:0] s4_sq2_full;
  logic [34:0]        s4_sq_q, s4_sq2_q;
  logic               s4_cold_q, s4_vcold_q;
  logic [18:0]        s4_temp_d, s4_temp_q;
  logic signed [39:0] s4_off1_q, s4_sens1_q;
  logic [23:0]        s4_d1_q;
  assign s4_tdiff2   = $signed({s3_tdiff_q[18], s3_tdiff_q})
                     + $signed(20'(psc_pkg::VeryColdOfs));
  assign s4_sq_full  = s3_tdiff_q * s3_tdiff_q;
  assign s4_sq2_full = s4_tdiff2 * s4_tdiff2;
  assign s4_temp_d   = s3_tdiff_q + 19'(psc_pkg::TempBase) - {2'b00, s3_t2_q};

  // Stage 5: second-order offset and sensitivity terms.
  logic [39:0] s5_sq_e, s5_sq2_e;
  logic [39:0] s5_a_d, s5_b_d, s5_c_d, s5_e_d, s5_a_q, s5_b_q, s5_c_q, s5_e_q;
  logic [18:0] s5_temp_q;
  logic signed [39:0] s5_off1_q, s5_sens1_q;
  logic [23:0] s5_d1_q;
  assign s5_sq_e  = {5'b00000, s4_sq_q};
  assign s5_sq2_e = {5'b00000, s4_sq2_q};
  assign s5_a_d   = s4_cold_q ? ((s5_sq_e + (s5_sq_e << 1)) >> 1) : (s5_sq_e >> 4);
  assign s5_b_d   = s4_vcold_q ? ((s5_sq2_e << 3) - s5_sq2_e) : 40'd0;
  assign s5_c_d   = s4_cold_q ? ((s5_sq_e + (s5_sq_e << 2)) >> 3) : 40'd0;
  assign s5_e_d   = s4_vcold_q ? (s5_sq2_e << 2) : 40'd0;

  // Stage 6: sum the correction terms.
  logic [39:0] s6_off2_q, s6_sens2_q;
  logic [18:0] s6_temp_q;
  logic signed [39:0] s6_off1_q, s6_sens1_q;
  logic [23:0] s6_d1_q;

  // Stage 7: final offset and sensitivity.
  logic signed [39:0] s7_off_q, s7_sens_q;
  logic [18:0] s7_temp_q;
  logic [23:0] s7_d1_q;

  // Stage 8: sens * d1 as two partial products.
  logic [43:0]        s8_pplo_q;
  logic signed [44:0] s8_pphi_d, s8_pphi_q;
  logic signed [39:0] s8_off_q;
  logic [18:0]        s8_temp_q;
  assign s8_pphi_d = $signed(s7_sens_q[39:20]) * $signed({1'b0, s7_d1_q});

  // Stage 9: recombine the product.
  logic [63:0]        s9_prod_q;
  logic signed [39:0] s9_off_q;
  logic [18:0]        s9_temp_q;

  // Stage 10: pressure before saturation.
  logic signed [45:0] s10_diff;
  logic signed [32:0] s10_p_q;
  logic [18:0]        s10_temp_q;
  assign s10_diff = $signed({{3{s9_prod_q[63]}}, s9_prod_q[63:21]})
                  - $signed({{6{s9_off_q[39]}}, s9_off_q});

  // Stage 11: saturate, threshold compare, output register.
  logic signed [30:0] s11_p_d, s11_p_q;
  logic               s11_sub_q, s11_crc_q;
  logic [18:0]        s11_temp_q;
  always_comb begin
    if (s10_p_q > $signed(33'(psc_pkg::PressMax))) begin
      s11_p_d = 31'(psc_pkg::PressMax);
    end else if (s10_p_q < $signed(33'(psc_pkg::PressMin))) begin
      s11_p_d = 31'(psc_pkg::PressMin);
    end else begin
      s11_p_d = s10_p_q[30:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_dt_q    <= s1_dt_d;
      s1_d1_q    <= s_axis_tdata[23:0];

      s2_pt_q    <= s2_pt_d;
      s2_po_q    <= s2_po_d;
      s2_ps_q    <= s2_ps_d;
      s2_dtsq_q  <= s2_sq_d[47:0];
      s2_d1_q    <= s1_d1_q;

      s3_tdiff_q <= s3_tdiff_d;
      s3_off1_q  <= s3_off1_d;
      s3_sens1_q <= s3_sens1_d;
      s3_t2_q    <= s3_t2_d;
      s3_d1_q    <= s2_d1_q;

      s4_sq_q    <= s4_sq_full[34:0];
      s4_sq2_q   <= s4_sq2_full[34:0];
      s4_cold_q  <= s3_tdiff_q[18];
      s4_vcold_q <= s4_tdiff2[19];
      s4_temp_q  <= s4_temp_d;
      s4_off1_q  <= s3_off1_q;
      s4_sens1_q <= s3_sens1_q;
      s4_d1_q    <= s3_d1_q;

      s5_a_q     <= s5_a_d;
      s5_b_q     <= s5_b_d;
      s5_c_q     <= s5_c_d;
      s5_e_q     <= s5_e_d;
      s5_temp_q  <= s4_temp_q;
      s5_off1_q  <= s4_off1_q;
      s5_sens1_q <= s4_sens1_q;
      s5_d1_q    <= s4_d1_q;

      s6_off2_q  <= s5_a_q + s5_b_q;
      s6_sens2_q <= s5_c_q + s5_e_q;
      s6_temp_q  <= s5_temp_q;
      s6_off1_q  <= s5_off1_q;
      s6_sens1_q <= s5_sens1_q;
      s6_d1_q    <= s5_d1_q;

      s7_off_q   <= s6_off1_q - $signed(s6_off2_q);
      s7_sens_q  <= s6_sens1_q - $signed(s6_sens2_q);
      s7_temp_q  <= s6_temp_q;
      s7_d1_q    <= s6_d1_q;

      s8_pplo_q  <= 44'(s7_sens_q[19:0]) * 44'(s7_d1_q);
      s8_pphi_q  <= s8_pphi_d;
      s8_off_q   <= s7_off_q;
      s8_temp_q  <= s7_temp_q;

      s9_prod_q  <= {s8_pphi_q[43:0], 20'h00000} + {20'h00000, s8_pplo_q};
      s9_off_q   <= s8_off_q;
      s9_temp_q  <= s8_temp_q;

      s10_p_q    <= s10_diff[45:13];
      s10_temp_q <= s9_temp_q;

      s11_p_q    <= s11_p_d;
      s11_sub_q  <= s11_p_d >= $signed({1'b0, thr_q});
      s11_crc_q  <= crc_st.bad;
      s11_temp_q <= s10_temp_q;
    end
  end

  assign m_axis_tvalid = v_q[psc_pkg::NumStages-1];
  assign m_axis_tdata  = {4'h0, s11_crc_q, s11_sub_q, s11_p_q, s11_temp_q};

  a_cfg_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_start |=> !s_axis_tready)
    else $error("input accepted while calibration CRC check runs");

  a_fire_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> v_q[0])
    else $error("accepted request did not enter the first stage");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while the output is stalled");

endmodule

// File: design/psc_crc.sv
module psc_crc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  psc_pkg::prom_words_t        words_i,
  output psc_pkg::crc_status_t        status_o
);

  logic [3:0]  cnt_q, cnt_d;
  logic [15:0] rem_q, rem_d;
  logic        busy_q, busy_d;
  logic        bad_q, bad_d;
  logic [15:0] word;
  logic [7:0]  data_byte;

  // The eighth word position is a zero pad; word zero loses its CRC nibble.
  always_comb begin
    word = 16'h0000;
    if (cnt_q[3:1] != 3'd7) begin
      word = words_i[cnt_q[3:1]];
    end
    if (cnt_q[3:1] == 3'd0) begin
      word = word & psc_pkg::CrcDataMask;
    end
    data_byte = cnt_q[0] ? word[7:0] : word[15:8];
  end

  always_comb begin
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    busy_d = busy_q;
    bad_d  = bad_q;
    if (start_i) begin
      cnt_d  = 4'd0;
      rem_d  = 16'h0000;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = psc_pkg::crc4_byte(rem_q ^ {8'h00, data_byte});
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        bad_d  = rem_d[15:12] != words_i[0][15:12];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 4'd0;
      rem_q  <= 16'h0000;
      busy_q <= 1'b0;
      bad_q  <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      busy_q <= busy_d;
      bad_q  <= bad_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.bad  = bad_q;

endmodule

// File: tb/psc_checker.sv
`timescale 1ns / 100ps

module psc_checker
  import psc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  // [23:0] raw_pressure, [47:24] raw_temperature
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  // [18:0] temperature_centi, [49:19] pressure_tenth_mbar, [50] submerged,
  // [51] crc_bad, [55:52] zero
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ThrW-1:0]     cfg_wdata_i,
  output int                  pending_o,
  output int                  fail_count_o,
  output logic [3:0]          crc_o
);

  localparam longint VeryColdLimit = -1500;

  typedef struct packed {
    logic signed [TempW-1:0]  temp_centi;
    logic signed [PressW-1:0] press_tenth;
    logic                     submerged;
    logic                     crc_bad;
  } reading_t;

  logic [WordW-1:0] cal_word [NumWords];
  logic [ThrW-1:0]  threshold;
  reading_t         reading_q [$];

  // CRC-4 over the calibration words, with the CRC nibble itself masked out and
  // a trailing zero word folded in.
  function automatic logic [3:0] calc_crc4();
    logic [15:0] rem;
    logic [15:0] w;
    rem = '0;
    for (int i = 0; i < 16; i++) begin
      w = (i / 2 < NumWords) ? cal_word[i / 2] : 16'h0000;
      if (i / 2 == 0) w = w & CrcDataMask;
      rem = rem ^ ((i % 2 == 1) ? {8'h00, w[7:0]} : {8'h00, w[15:8]});
      for (int b = 0; b < 8; b++) begin
        rem = rem[15] ? ({rem[14:0], 1'b0} ^ CrcPoly) : {rem[14:0], 1'b0};
      end
    end
    return rem[15:12];
  endfunction

  function automatic reading_t compensate(input logic [RawW-1:0] d1_raw,
                                          input logic [RawW-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, temp, off, sens, t2, off2, sens2, sq, sq2, p;
    reading_t r;
    d1 = $signed({40'd0, d1_raw});
    d2 = $signed({40'd0, d2_raw});
    c1 = $signed({48'd0, cal_word[RegSensCoeff]});
    c2 = $signed({48'd0, cal_word[RegOffsetCoeff]});
    c3 = $signed({48'd0, cal_word[RegSensTemp]});
    c4 = $signed({48'd0, cal_word[RegOffsetTemp]});
    c5 = $signed({48'd0, cal_word[RegRefTemp]});
    c6 = $signed({48'd0, cal_word[RegTempSlope]});

    dt   = d2 - c5 * 256;
    temp = TempBase + ((dt * c6) >>> 23);
    off  = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);

    sq = (temp - TempBase) * (temp - TempBase);
    if (temp < TempBase) begin
      t2    = (3 * dt * dt) >>> 33;
      off2  = (3 * sq) >>> 1;
      sens2 = (5 * sq) >>> 3;
      if (temp < VeryColdLimit) begin
        sq2   = (temp - VeryColdLimit) * (temp - VeryColdLimit);
        off2  = off2 + 7 * sq2;
        sens2 = sens2 + 4 * sq2;
      end
    end else begin
      t2    = (2 * dt * dt) >>> 37;
      off2  = sq >>> 4;
      sens2 = 0;
    end

    temp = temp - t2;
    off  = off - off2;
    sens = sens - sens2;

    p = (((sens * d1) >>> 21) - off) >>> 13;
    if (p > PressMax) p = PressMax;
    if (p < PressMin) p = PressMin;

    r.temp_centi  = temp[TempW-1:0];
    r.press_tenth = p[PressW-1:0];
    r.submerged   = (p >= $signed({34'd0, threshold}));
    r.crc_bad     = (calc_crc4() != cal_word[RegCrcWord][15:12]);
    return r;
  endfunction

  // Everything is sampled at the falling edge, where all signals are stable;
  // a request seen here completes at the following rising edge.
  always @(negedge clk_i) begin
    reading_t got;
    reading_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumWords; i++) cal_word[i] = '0;
      threshold = '0;
      reading_q.delete();
      fail_count_o = 0;
      crc_o = calc_crc4();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == RegThreshold) begin
          threshold = cfg_wdata_i;
        end else begin
          cal_word[cfg_idx_i] = cfg_wdata_i[WordW-1:0];
        end
        crc_o = calc_crc4();
      end

      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got.temp_centi  = m_axis_tdata_i[TempW-1:0];
        got.press_tenth = m_axis_tdata_i[TempW +: PressW];
        got.submerged   = m_axis_tdata_i[TempW + PressW];
        got.crc_bad     = m_axis_tdata_i[TempW + PressW + 1];
        if (reading_q.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("%0t: result with no request pending: temp %0d press %0d sub %0b crc %0b",
                     $realtime, got.temp_centi, got.press_tenth, got.submerged,
                     got.crc_bad);
          end
          fail_count_o++;
        end else begin
          want = reading_q.pop_front();
          if (got != want || m_axis_tdata_i[OutDataW-1:TempW+PressW+2] != '0) begin
            if (fail_count_o < 10) begin
              $display("%0t: mismatch temp exp %0d got %0d, press exp %0d got %0d",
                       $realtime, want.temp_centi, got.temp_centi,
                       want.press_tenth, got.press_tenth);
              $display("  submerged exp %0b got %0b, crc_bad exp %0b got %0b, pad %h",
                       want.submerged, got.submerged, want.crc_bad, got.crc_bad,
                       m_axis_tdata_i[OutDataW-1:TempW+PressW+2]);
            end
            fail_count_o++;
          end
        end
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        reading_q.push_back(compensate(s_axis_tdata_i[RawW-1:0],
                                       s_axis_tdata_i[2*RawW-1:RawW]));
      end
    end
    pending_o = reading_q.size();
  end

endmodule

// File: tb/tb_pressure_sensor_compensation.sv
`timescale 1ns / 100ps

module tb_pressure_sensor_compensation;
  import psc_pkg::*;

  typedef enum int {
    CalTypical,
    CalRandomValid,
    CalMax,
    CalRandomBad,
    CalMin
  } cal_kind_e;

  localparam int PhaseItems   = 295;
  localparam int RxHoldCycles = 300;
  localparam int StallLimit   = 2000;
  localparam int RawMax       = (1 << RawW) - 1;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [ThrW-1:0]     cfg_wdata;

  int         pending;
  int         fail_count;
  logic [3:0] crc_calc;

  logic       quiet;
  logic       rx_hold;
  int         stall_cycles;
  longint     ref_temp_word;
  longint     slope_word;

  pressure_sensor_compensation u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata)
  );

  psc_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .pending_o       (pending),
    .fail_count_o    (fail_count),
    .crc_o           (crc_calc)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [RawW-1:0] clamp_raw(input longint v);
    if (v < 0) return '0;
    if (v > RawMax) return RawW'(RawMax);
    return v[RawW-1:0];
  endfunction

  task automatic send_sample(input logic [RawW-1:0] d1, input logic [RawW-1:0] d2);
    while (!quiet && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= InDataW'({$urandom, $urandom});
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d2, d1};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic send_random();
    logic [RawW-1:0] d1;
    logic [RawW-1:0] d2;
    d1 = RawW'($urandom_range(0, RawMax));
    case ($urandom_range(3))
      0, 1:    d2 = clamp_raw(ref_temp_word * 256 + $urandom_range(0, 3000000) - 1500000);
      2:       d2 = RawW'($urandom_range(0, RawMax));
      default: d2 = RawW'($urandom_range(1) ? RawMax - $urandom_range(255)
                                            : $urandom_range(255));
    endcase
    send_sample(d1, d2);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ThrW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
  endtask

  task automatic load_calibration(input cal_kind_e kind);
    logic [WordW-1:0] w [NumWords];
    logic [ThrW-1:0]  thr;
    logic [ThrW-1:0]  v;
    drain();
    // Let the pipeline empty fully before touching the registers.
    repeat (NumStages + 4) @(posedge clk_i);
    for (int i = 0; i < NumWords; i++) w[i] = WordW'($urandom);
    thr = ThrW'($urandom);
    case (kind)
      CalTypical: begin
        w[RegSensCoeff]   = 16'd34982;
        w[RegOffsetCoeff] = 16'd36352;
        w[RegSensTemp]    = 16'd20328;
        w[RegOffsetTemp]  = 16'd22354;
        w[RegRefTemp]     = 16'd26646;
        w[RegTempSlope]   = 16'd26146;
        thr = 30'd20000;
      end
      CalRandomValid: thr = ThrW'($urandom_range(0, 60000));
      CalMax: begin
        for (int i = 0; i < NumWords; i++) w[i] = 16'hFFFF;
        thr = '1;
      end
      CalMin: begin
        for (int i = 0; i < NumWords; i++) w[i] = 16'h0000;
        w[RegCrcWord] = 16'hF000;
        thr = '0;
      end
      default: ;
    endcase
    for (int i = 0; i < NumWords; i++) begin
      // Upper write data bits are junk for the 16-bit words.
      v = ThrW'($urandom);
      v[WordW-1:0] = w[i];
      write_reg(i[CfgIdxW-1:0], v);
    end
    write_reg(RegThreshold, thr);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (kind == CalTypical || kind == CalRandomValid) begin
      v = '0;
      v[WordW-1:0] = {crc_calc, w[RegCrcWord][11:0]};
      write_reg(RegCrcWord, v);
      cfg_we <= 1'b0;
      @(posedge clk_i);
    end
    ref_temp_word = longint'(w[RegRefTemp]);
    slope_word    = longint'(w[RegTempSlope]);
  endtask

  // Receiver side: random back-pressure, plus one long hold-off on request.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold) begin
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold = 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 34);
      end
    end
  end

  always @(negedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int     temps [10];
    longint dt;
    stall_cycles  = 0;
    quiet         = 1'b0;
    rx_hold       = 1'b0;
    ref_temp_word = 0;
    slope_word    = 0;
    temps = '{-4000, -1501, -1500, -1499, 0, 1999, 2000, 2001, 4500, 8500};
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_we        <= 1'b0;
    cfg_idx       <= '0;
    cfg_wdata     <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // All calibration words at their reset value of zero.
    for (int n = 0; n < 20; n++) send_random();

    load_calibration(CalTypical);
    send_sample('0, '0);
    send_sample(RawW'(RawMax), '0);
    send_sample('0, RawW'(RawMax));
    send_sample(RawW'(RawMax), RawW'(RawMax));
    // Walk the first-order temperature across the cold, very cold and warm
    // band edges.
    foreach (temps[i]) begin
      dt = ((longint'(temps[i]) - TempBase) * (64'sd1 <<< 23)) / slope_word;
      send_sample(24'd4958179, clamp_raw(ref_temp_word * 256 + dt));
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       load_calibration(CalTypical);
        1:       load_calibration(CalRandomValid);
        2:       load_calibration(CalMax);
        3:       load_calibration(CalRandomBad);
        4:       load_calibration(CalMin);
        default: load_calibration(CalRandomValid);
      endcase
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 1 && n == 150) drain();
        if (ph == 2 && n == 100) rx_hold = 1'b1;
        if (ph == 3) quiet = (n < 200);
        send_random();
      end
      quiet = 1'b0;
    end

    drain();
    repeat (NumStages + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
